[rtl/rpa_pkg.sv]
// Relay autotuner package: payload structs, register indexes, constants.
// Used by every file of the relay autotuner; depends on nothing.
package rpa_pkg;

   localparam int POS_W   = 15;
   localparam int TIME_W  = 32;
   localparam int AMP_W   = 7;
   localparam int CSR_W   = 15;
   localparam int GAIN_W  = 32;
   localparam int FA_W    = 32;
   localparam int FP_W    = 40;

   // serial arithmetic widths
   localparam int DIV_XW  = 96;
   localparam int DIV_DW  = 48;
   localparam int MUL_AW  = 64;

   localparam int DEF_CYCLES_PER_GAIN = 5;

   localparam logic [POS_W-1:0] POS_FULL       = 15'd25600;
   localparam logic [AMP_W-1:0] AMP_MAX        = 7'd100;
   localparam logic [POS_W-1:0] THRESHOLD_RST  = 15'd15360;
   localparam logic [AMP_W-1:0] AMPLITUDE_RST  = 7'd20;

   localparam logic [19:0] AMP_SCALE   = 20'd800000;  // 8 * 100000
   localparam logic [18:0] PI_SCALE    = 19'd314159;
   localparam logic [25:0] KI_SCALE    = 26'd64000000;
   localparam logic [31:0] KD_DIV      = 32'd3200000000;
   localparam logic [6:0]  KP_DIV      = 7'd100;
   localparam logic [4:0]  FILT_DIV    = 5'd20;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_AMPLITUDE = 1'b1;

   localparam logic [1:0] SEL_KP = 2'd0;
   localparam logic [1:0] SEL_KI = 2'd1;
   localparam logic [1:0] SEL_KD = 2'd2;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [TIME_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic signed [7:0] drive;
      logic              gain_valid;
      logic [1:0]        gain_select;
      logic [GAIN_W-1:0] gain_value;
      logic              gain_error;
   } rsp_type;

endpackage

[rtl/rpa_mul.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on rpa_pkg for operand widths.
module rpa_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [rpa_pkg::MUL_AW-1:0]     a,
   input  logic [rpa_pkg::DIV_DW-1:0]     b,
   output logic                           done,
   output logic [rpa_pkg::DIV_XW-1:0]     prod
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [rpa_pkg::DIV_XW-1:0]    a_ff, a_in;
   logic [rpa_pkg::DIV_DW-1:0]    b_ff, b_in;
   logic [rpa_pkg::DIV_XW-1:0]    acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (go) begin
         a_in    = rpa_pkg::DIV_XW'(a);
         b_in    = b;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (b_ff[0]) acc_in = acc_ff + a_ff;
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

[rtl/rpa_div.sv]
// Restoring bit-serial divider giving round(x / d), halves up; one quotient bit a cycle.
// Depends on rpa_pkg for operand widths.
module rpa_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [rpa_pkg::DIV_XW-1:0]  x,
   input  logic [rpa_pkg::DIV_DW-1:0]  d,
   output logic                        done,
   output logic [rpa_pkg::DIV_XW-1:0]  q
);

   localparam int CNT_W = $clog2(rpa_pkg::DIV_XW);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [rpa_pkg::DIV_XW-1:0]    dvd_ff, dvd_in;
   logic [rpa_pkg::DIV_DW-1:0]    rem_ff, rem_in;
   logic [rpa_pkg::DIV_DW-1:0]    dsr_ff, dsr_in;
   logic [rpa_pkg::DIV_DW:0]      rem_sh, rem_sub;
   logic                          fits;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[rpa_pkg::DIV_XW-1]};
      fits    = rem_sh >= {1'b0, dsr_ff};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (go) begin
         // pre-add half the divisor for round to nearest
         dvd_in  = x + rpa_pkg::DIV_XW'(d >> 1);
         rem_in  = '0;
         dsr_in  = d;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[rpa_pkg::DIV_DW-1:0] : rem_sh[rpa_pkg::DIV_DW-1:0];
         dvd_in = {dvd_ff[rpa_pkg::DIV_XW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(rpa_pkg::DIV_XW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign q    = dvd_ff;

endmodule

[rtl/relay_pid_autotuner_unit.sv]
// Relay autotuner top level: relay drive, cycle tracking, filters and gain sequencer.
// Depends on rpa_pkg, rpa_mul and rpa_div.
// A tick with no falling crossing gives its registered result in the cycle after transfer.
// A falling crossing runs serial divider passes: two when the filtered amplitude or
// period is zero, else four plus one serial multiply for Kp or two for Ki and Kd.
// One tick at a time.
// Reset (synchronous, active high) restores the config registers and tracking state to defaults.
module relay_pid_autotuner_unit #(
   parameter int CYCLES_PER_GAIN = rpa_pkg::DEF_CYCLES_PER_GAIN
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rpa_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rpa_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [rpa_pkg::CSR_W-1:0] csr_wdata
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FA   = 3'd1;  // amplitude filter divide
   localparam logic [2:0] ST_FP   = 3'd2;  // period filter divide
   localparam logic [2:0] ST_DEN  = 3'd3;  // pi * amplitude multiply
   localparam logic [2:0] ST_KU   = 3'd4;  // ultimate gain divide
   localparam logic [2:0] ST_GM   = 3'd5;  // Ki / Kd multiply
   localparam logic [2:0] ST_GD   = 3'd6;  // final gain divide

   localparam int XW = rpa_pkg::DIV_XW;
   localparam int DW = rpa_pkg::DIV_DW;

   // config registers
   logic [rpa_pkg::POS_W-1:0] thr_ff, thr_in;
   logic [rpa_pkg::AMP_W-1:0] amp_ff, amp_in;

   // tracking state
   logic                       above_ff, above_in;
   logic [31:0]                start_ff, start_in;
   logic [rpa_pkg::POS_W-1:0]  min_ff, min_in, max_ff, max_in;
   logic [rpa_pkg::FA_W-1:0]   fa_ff, fa_in;
   logic [rpa_pkg::FP_W-1:0]   fp_ff, fp_in;
   logic [2:0]                 cnt_ff, cnt_in;
   logic [1:0]                 sel_ff, sel_in;

   // sequencer
   logic [2:0]                 state_ff, state_in;
   logic [rpa_pkg::FP_W-1:0]   px_ff, px_in;
   logic signed [7:0]          drive_ff, drive_in;

   // arithmetic unit launch
   logic                       div_go_ff, div_go_in, mul_go_ff, mul_go_in;
   logic [XW-1:0]              div_x_ff, div_x_in;
   logic [DW-1:0]              div_d_ff, div_d_in, mul_b_ff, mul_b_in;
   logic [rpa_pkg::MUL_AW-1:0] mul_a_ff, mul_a_in;
   logic                       div_done, mul_done;
   logic [XW-1:0]              div_q, mul_p;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   rpa_pkg::rsp_type           rsp_ff, rsp_in;

   // per-tick combinational
   logic [rpa_pkg::POS_W-1:0]  pos_sat;
   logic [rpa_pkg::AMP_W-1:0]  amp_sat;
   logic                       above, falling, accept;
   logic signed [7:0]          drive;
   logic [22:0]                ax;
   logic [2:0]                 cnt_next;
   logic [1:0]                 sel_next;
   logic [26:0]                num_hi;
   logic [rpa_pkg::FP_W-1:0]   fp_new;
   logic [rpa_pkg::GAIN_W-1:0] gain_sat;

   rpa_mul u_mul (
      .clock (clock), .reset (reset), .go (mul_go_ff),
      .a (mul_a_ff), .b (mul_b_ff), .done (mul_done), .prod (mul_p)
   );

   rpa_div u_div (
      .clock (clock), .reset (reset), .go (div_go_ff),
      .x (div_x_ff), .d (div_d_ff), .done (div_done), .q (div_q)
   );

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      pos_sat = (req_data.position > rpa_pkg::POS_FULL) ? rpa_pkg::POS_FULL
                                                         : req_data.position;
      amp_sat = (amp_ff > rpa_pkg::AMP_MAX) ? rpa_pkg::AMP_MAX : amp_ff;
      above   = pos_sat > thr_ff;
      falling = above_ff && !above;
      drive   = above ? -$signed({1'b0, amp_sat}) : $signed({1'b0, amp_sat});
      // peak-to-peak; inverted bounds (no sample yet) count as zero
      ax      = (max_ff > min_ff) ? {max_ff - min_ff, 8'b0} : '0;
      // gain rotation: counter rolls over at CYCLES_PER_GAIN
      if (32'(cnt_ff) >= 32'(CYCLES_PER_GAIN)) begin
         cnt_next = 3'd1;
         sel_next = (sel_ff >= 2'd2) ? rpa_pkg::SEL_KP : sel_ff + 2'd1;
      end else begin
         cnt_next = cnt_ff + 3'd1;
         sel_next = sel_ff;
      end
      num_hi   = 27'(amp_sat) * 27'(rpa_pkg::AMP_SCALE);
      fp_new   = div_q[rpa_pkg::FP_W-1:0];
      gain_sat = (|div_q[XW-1:rpa_pkg::GAIN_W]) ? '1 : div_q[rpa_pkg::GAIN_W-1:0];
   end

   always_comb begin
      thr_in   = thr_ff;
      amp_in   = amp_ff;
      above_in = above_ff;
      start_in = start_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      fa_in    = fa_ff;
      fp_in    = fp_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      state_in = state_ff;
      px_in    = px_ff;
      drive_in = drive_ff;
      div_go_in = 1'b0;
      mul_go_in = 1'b0;
      div_x_in = div_x_ff;
      div_d_in = div_d_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in   = rsp_ff;

      if (csr_we) begin
         case (csr_index)
            rpa_pkg::CSR_THRESHOLD: thr_in = csr_wdata;
            rpa_pkg::CSR_AMPLITUDE: amp_in = csr_wdata[rpa_pkg::AMP_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               above_in = above;
               drive_in = drive;
               if (falling) begin
                  // cycle end: bounds restart from this sample
                  start_in = req_data.time_us;
                  px_in    = {req_data.time_us - start_ff, 8'b0};
                  min_in   = pos_sat;
                  max_in   = pos_sat;
                  cnt_in   = cnt_next;
                  sel_in   = sel_next;
                  div_x_in = XW'(ax) + XW'(fa_ff) + (XW'(fa_ff) << 4) + (XW'(fa_ff) << 1);
                  div_d_in = DW'(rpa_pkg::FILT_DIV);
                  div_go_in = 1'b1;
                  state_in = ST_FA;
               end else begin
                  if (pos_sat < min_ff) min_in = pos_sat;
                  if (pos_sat > max_ff) max_in = pos_sat;
                  rsp_valid_in = 1'b1;
                  rsp_in = '{drive: drive, gain_valid: 1'b0, gain_select: 2'd0,
                             gain_value: '0, gain_error: 1'b0};
               end
            end
         end
         ST_FA: begin
            if (div_done) begin
               fa_in    = div_q[rpa_pkg::FA_W-1:0];
               div_x_in = XW'(px_ff) + XW'(fp_ff) + (XW'(fp_ff) << 4) + (XW'(fp_ff) << 1);
               div_d_in = DW'(rpa_pkg::FILT_DIV);
               div_go_in = 1'b1;
               state_in = ST_FP;
            end
         end
         ST_FP: begin
            if (div_done) begin
               fp_in = fp_new;
               if (fa_ff == '0 || fp_new == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{drive: drive_ff, gain_valid: 1'b1, gain_select: sel_ff,
                             gain_value: '1, gain_error: 1'b1};
                  state_in = ST_IDLE;
               end else begin
                  mul_a_in  = rpa_pkg::MUL_AW'(fa_ff);
                  mul_b_in  = DW'(rpa_pkg::PI_SCALE);
                  mul_go_in = 1'b1;
                  state_in  = ST_DEN;
               end
            end
         end
         ST_DEN: begin
            if (mul_done) begin
               div_x_in  = {37'b0, num_hi, 32'b0};
               div_d_in  = mul_p[DW-1:0];
               div_go_in = 1'b1;
               state_in  = ST_KU;
            end
         end
         ST_KU: begin
            if (div_done) begin
               case (sel_ff)
                  rpa_pkg::SEL_KP: begin
                     div_x_in  = XW'(div_q[63:0]) + (XW'(div_q[63:0]) << 5)
                               + (XW'(div_q[63:0]) << 1);
                     div_d_in  = DW'(rpa_pkg::KP_DIV);
                     div_go_in = 1'b1;
                     state_in  = ST_GD;
                  end
                  rpa_pkg::SEL_KI: begin
                     mul_a_in  = div_q[63:0];
                     mul_b_in  = DW'(rpa_pkg::KI_SCALE);
                     mul_go_in = 1'b1;
                     state_in  = ST_GM;
                  end
                  default: begin
                     mul_a_in  = div_q[63:0];
                     mul_b_in  = DW'(fp_ff);
                     mul_go_in = 1'b1;
                     state_in  = ST_GM;
                  end
               endcase
            end
         end
         ST_GM: begin
            if (mul_done) begin
               div_x_in  = mul_p;
               div_d_in  = (sel_ff == rpa_pkg::SEL_KI) ? DW'(fp_ff) : DW'(rpa_pkg::KD_DIV);
               div_go_in = 1'b1;
               state_in  = ST_GD;
            end
         end
         ST_GD: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{drive: drive_ff, gain_valid: 1'b1, gain_select: sel_ff,
                          gain_value: gain_sat, gain_error: 1'b0};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= rpa_pkg::THRESHOLD_RST;
         amp_ff       <= rpa_pkg::AMPLITUDE_RST;
         above_ff     <= 1'b0;
         start_ff     <= '0;
         min_ff       <= rpa_pkg::POS_FULL;
         max_ff       <= '0;
         fa_ff        <= '0;
         fp_ff        <= '0;
         cnt_ff       <= '0;
         sel_ff       <= '0;
         state_ff     <= ST_IDLE;
         div_go_ff    <= 1'b0;
         mul_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         amp_ff       <= amp_in;
         above_ff     <= above_in;
         start_ff     <= start_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         fa_ff        <= fa_in;
         fp_ff        <= fp_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         state_ff     <= state_in;
         div_go_ff    <= div_go_in;
         mul_go_ff    <= mul_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff    <= px_in;
      drive_ff <= drive_in;
      div_x_ff <= div_x_in;
      div_d_ff <= div_d_in;
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[rtl/rpa_checker.sv]
// Port-level checker for the relay autotuner, bound to the top level.
// Depends on rpa_pkg and relay_pid_autotuner_unit.
module rpa_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rpa_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_no_gain_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.gain_valid |->
         rsp_data.gain_value == '0 && !rsp_data.gain_error && rsp_data.gain_select == 2'd0)
      else $error("gain fields set without cycle end");

   a_err_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.gain_error |->
         rsp_data.gain_valid && rsp_data.gain_value == 32'hFFFF_FFFF)
      else $error("error flag without saturated gain");

   a_sel_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.gain_select != 2'd3 &&
         rsp_data.drive <= 8'sd100 && rsp_data.drive >= -8'sd100)
      else $error("select or drive out of range");

endmodule

bind relay_pid_autotuner_unit rpa_checker u_rpa_checker (
   .clock (clock), .reset (reset), .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall), .rsp_data (rsp_data)
);
